[hdl/trrl_pkg.sv]
// Package for the time read record/replay log unit: log sizing, request and
// mode codes, stream payload layouts and the log write-port bundle.
// Depends on nothing; every module of the unit imports it.
package trrl_pkg;

    // Log sizing
    localparam int LOG_DEPTH = 1024;
    localparam int LOG_AW    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

    // Field widths
    localparam int REQ_W   = 2;
    localparam int TIME_W  = 64;
    localparam int TALLY_W = 32;
    localparam int MODE_W  = 2;

    // Stream payload widths, padded to whole bytes
    localparam int IN_BITS   = REQ_W + 3 * TIME_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = TIME_W + 1 + CNT_W + 2 * TALLY_W + TIME_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = MODE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIVE_PRESENT = 1'd1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EPOCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd2;

    // Operating modes; the unused code behaves as pass-through
    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RECORD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPLAY = 2'd2;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    typedef struct packed {
        logic              we;
        logic [LOG_AW-1:0] addr;
        logic [TIME_W-1:0] data;
    } log_wr_t;

endpackage

[hdl/trrl_log_ram.sv]
// Log store: single write port, one registered read port, write-first when
// both ports hit the same entry in one cycle.
// Depends on trrl_pkg.
module trrl_log_ram
    import trrl_pkg::*;
(
    input  logic              clk,
    input  log_wr_t           wr,
    input  logic [LOG_AW-1:0] raddr,
    output logic [TIME_W-1:0] rdata
);

    logic [TIME_W-1:0] mem [LOG_DEPTH];
    logic [TIME_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Forward the word being written so the prefetched entry is never stale
    always_ff @(posedge clk)
    begin
        if (wr.we && (wr.addr == raddr))
        begin
            rdata_reg <= wr.data;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/time_read_record_replay_log_unit.sv]
// Top level of the time read record/replay log unit: request input register,
// request decode and state update, result register.
// Depends on trrl_pkg and trrl_log_ram.
//
//   channel   | direction | payload (lowest bits first)
//   ----------+-----------+-----------------------------------------------------
//   s_axis    | in        | req_type, live_time, epoch_value, load_value
//   m_axis    | out       | time_value, status, recorded_count, overflow_count,
//             |           | underflow_count, current_epoch
//   cfg       | in        | index 0 operating_mode, index 1 live_source_present
//
// One request per cycle is sustained while m_axis does not stall: a request is held in the input
// register and is resolved from there into the result register.
// The log read port prefetches the entry under the replay cursor every cycle,
// so a replay read finds its word waiting and never has to wait on the log.
// Reset clears the counters, cursor, last value, epoch and both valid flags;
// log contents stay undefined until written.
// A stall on m_axis holds the result register and then the input register.
module time_read_record_replay_log_unit
    import trrl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // requests
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // req_type, live_time, epoch_value,
                                                 // load_value, zero pad
    // results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // time_value, status, recorded_count,
                                                 // overflow_count, underflow_count,
                                                 // current_epoch, zero pad
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MODE_W-1:0] mode_reg;
    logic              live_present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_OFF;
            live_present_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:         mode_reg         <= cfg_data;
                CFG_LIVE_PRESENT: live_present_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register: a request waits here until it can resolve into the result register
    // ------------------------------------------------------------------
    logic                 in_valid_reg;
    logic [REQ_W-1:0]     req_reg;
    logic [TIME_W-1:0]    live_reg;
    logic [TIME_W-1:0]    epoch_in_reg;
    logic [TIME_W-1:0]    load_in_reg;

    logic out_free;
    logic advance;   // the held request resolves into the result register

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            req_reg      <= s_axis_tdata[REQ_W-1:0];
            live_reg     <= s_axis_tdata[REQ_W +: TIME_W];
            epoch_in_reg <= s_axis_tdata[REQ_W + TIME_W +: TIME_W];
            load_in_reg  <= s_axis_tdata[REQ_W + 2 * TIME_W +: TIME_W];
        end
    end

    // ------------------------------------------------------------------
    // Unit state
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [CNT_W-1:0]   cursor_reg, cursor_next;
    logic [TALLY_W-1:0] ovf_reg,    ovf_next;
    logic [TALLY_W-1:0] unf_reg,    unf_next;
    logic [TIME_W-1:0]  last_reg,   last_next;
    logic [TIME_W-1:0]  epoch_reg,  epoch_next;

    logic [TIME_W-1:0]  sample;
    logic [TIME_W-1:0]  time_val;
    logic               status_val;
    logic               log_room;
    logic [TIME_W-1:0]  log_rdata;
    logic [LOG_AW-1:0]  raddr;
    log_wr_t            log_wr;

    // With no live source a read outside replay mode repeats the last value
    assign sample   = live_present_reg ? live_reg : last_reg;
    assign log_room = (count_reg < CNT_W'(LOG_DEPTH));

    always_comb
    begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        ovf_next    = ovf_reg;
        unf_next    = unf_reg;
        last_next   = last_reg;
        epoch_next  = epoch_reg;
        time_val    = last_reg;
        status_val  = 1'b0;
        log_wr.we   = 1'b0;
        log_wr.addr = count_reg[LOG_AW-1:0];
        log_wr.data = sample;

        case (req_reg)
            REQ_READ:
            begin
                case (mode_reg)
                    MODE_RECORD:
                    begin
                        time_val = sample;
                        if (log_room)
                        begin
                            log_wr.we  = advance;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else if (ovf_reg != TALLY_MAX)
                        begin
                            ovf_next = ovf_reg + TALLY_W'(1);
                        end
                    end
                    MODE_REPLAY:
                    begin
                        // cursor below count implies cursor below depth
                        if (cursor_reg < count_reg)
                        begin
                            time_val    = log_rdata;
                            cursor_next = cursor_reg + CNT_W'(1);
                        end
                        else if (unf_reg != TALLY_MAX)
                        begin
                            unf_next = unf_reg + TALLY_W'(1);
                        end
                    end
                    default:
                    begin
                        time_val = sample;
                    end
                endcase
                last_next = time_val;
            end
            REQ_EPOCH:
            begin
                epoch_next  = epoch_in_reg;
                count_next  = '0;
                cursor_next = '0;
                ovf_next    = '0;
                unf_next    = '0;
            end
            REQ_LOAD:
            begin
                log_wr.data = load_in_reg;
                if (log_room)
                begin
                    log_wr.we  = advance;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    status_val = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            cursor_reg <= '0;
            ovf_reg    <= '0;
            unf_reg    <= '0;
            last_reg   <= '0;
            epoch_reg  <= '0;
        end
        else if (advance)
        begin
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            ovf_reg    <= ovf_next;
            unf_reg    <= unf_next;
            last_reg   <= last_next;
            epoch_reg  <= epoch_next;
        end
    end

    // Prefetch the entry the cursor will point at on the next cycle
    assign raddr = advance ? cursor_next[LOG_AW-1:0] : cursor_reg[LOG_AW-1:0];

    trrl_log_ram u_log_ram
    (
        .clk   (clk),
        .wr    (log_wr),
        .raddr (raddr),
        .rdata (log_rdata)
    );

    // ------------------------------------------------------------------
    // Result register: hold until the downstream side takes the transaction
    // ------------------------------------------------------------------
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= OUT_DATA_W'({epoch_next, unf_next, ovf_next,
                                         count_next, status_val, time_val});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[tb/tb_trrl_result_checker.sv]
`timescale 1ns / 100ps
// Result checker for the time read record/replay log unit: follows register
// writes and request transactions, predicts every result and compares it on m_axis.
// Depends on trrl_pkg.
module tb_trrl_result_checker
    import trrl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    output int                    fail_count,
    output int                    pending,
    output int                    checked
);

    // Payload layouts; the last member sits in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0] load_value;
        logic [TIME_W-1:0] epoch_value;
        logic [TIME_W-1:0] live_time;
        logic [REQ_W-1:0]  req_type;
    } clock_request_t;

    typedef struct packed {
        logic [TIME_W-1:0]  current_epoch;
        logic [TALLY_W-1:0] underflow_count;
        logic [TALLY_W-1:0] overflow_count;
        logic [CNT_W-1:0]   recorded_count;
        logic               status;
        logic [TIME_W-1:0]  time_value;
    } clock_result_t;

    // Shadow state of the unit
    bit [TIME_W-1:0]  log_mem [LOG_DEPTH];
    int unsigned      entries;
    int unsigned      cursor;
    bit [TALLY_W-1:0] overflows;
    bit [TALLY_W-1:0] underflows;
    bit [TIME_W-1:0]  last_time;
    bit [TIME_W-1:0]  epoch_id;
    bit [MODE_W-1:0]  mode;
    bit               live_present;

    clock_result_t expected_results[$];

    function automatic clock_result_t resolve_request(input clock_request_t rq);
        clock_result_t   r;
        bit [TIME_W-1:0] v;
        r = '0;
        v = last_time;
        case (rq.req_type)
            REQ_READ:
            begin
                if (mode == MODE_REPLAY)
                begin
                    if (cursor < entries)
                    begin
                        v = log_mem[cursor];
                        cursor++;
                    end
                    else if (underflows != TALLY_MAX)
                        underflows++;
                end
                else
                begin
                    // off, record and the unused mode all sample the live clock
                    v = live_present ? rq.live_time : last_time;
                    if (mode == MODE_RECORD)
                    begin
                        if (entries < LOG_DEPTH)
                        begin
                            log_mem[entries] = v;
                            entries++;
                        end
                        else if (overflows != TALLY_MAX)
                            overflows++;
                    end
                end
                last_time = v;
            end
            REQ_EPOCH:
            begin
                epoch_id    = rq.epoch_value;
                entries     = 0;
                cursor      = 0;
                overflows   = '0;
                underflows  = '0;
            end
            REQ_LOAD:
            begin
                if (entries < LOG_DEPTH)
                begin
                    log_mem[entries] = rq.load_value;
                    entries++;
                end
                else
                    r.status = 1'b1;
            end
            default: ;
        endcase
        r.time_value      = v;
        r.recorded_count  = CNT_W'(entries);
        r.overflow_count  = overflows;
        r.underflow_count = underflows;
        r.current_epoch   = epoch_id;
        return r;
    endfunction

    task automatic compare_field(input string fname, input logic [TIME_W-1:0] want,
                                 input logic [TIME_W-1:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: result %0d field %s expected %h got %h",
                         $realtime, checked, fname, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        clock_result_t seen;
        clock_result_t want;
        if (!rst_n)
        begin
            entries      = 0;
            cursor       = 0;
            overflows    = '0;
            underflows   = '0;
            last_time    = '0;
            epoch_id     = '0;
            mode         = MODE_OFF;
            live_present = 1'b1;
            expected_results.delete();
            pending      = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MODE)
                    mode = cfg_data[MODE_W-1:0];
                else if (cfg_index == CFG_LIVE_PRESENT)
                    live_present = cfg_data[0];
            end
            // retire before predicting: a result never belongs to the request
            // accepted at the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = clock_result_t'(m_axis_tdata[OUT_BITS-1:0]);
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result, time_value %h",
                                 $realtime, seen.time_value);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("time_value", want.time_value, seen.time_value);
                    compare_field("status", TIME_W'(want.status), TIME_W'(seen.status));
                    compare_field("recorded_count", TIME_W'(want.recorded_count),
                                  TIME_W'(seen.recorded_count));
                    compare_field("overflow_count", TIME_W'(want.overflow_count),
                                  TIME_W'(seen.overflow_count));
                    compare_field("underflow_count", TIME_W'(want.underflow_count),
                                  TIME_W'(seen.underflow_count));
                    compare_field("current_epoch", want.current_epoch, seen.current_epoch);
                    checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(
                    resolve_request(clock_request_t'(s_axis_tdata[IN_BITS-1:0])));
            pending = expected_results.size();
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for the time read record/replay log unit: clock, reset, request
// and register stimulus, receiver back-pressure and the verdict.
// Depends on trrl_pkg, time_read_record_replay_log_unit and tb_trrl_result_checker.
module tb_top;
    import trrl_pkg::*;

    // Codes the package leaves unnamed but the unit must still handle
    localparam logic [REQ_W-1:0]  REQ_UNUSED  = 2'd3;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RANDOM_ITEMS    = 120;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // req_type, live_time, epoch_value,
                                           // load_value, zero pad
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // time_value, status, recorded_count,
                                           // overflow_count, underflow_count,
                                           // current_epoch, zero pad

    int fail_count;
    int pending;
    int checked;

    int              burst_left;
    int              items_sent;
    int              cfg_writes;
    int              hold_off_req;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    time_read_record_replay_log_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tb_trrl_result_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked)
    );

    // Mostly full-range values, with the all-zero and all-one extremes mixed in
    function automatic logic [TIME_W-1:0] rand_time();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Weighted request code; whatever is left of the hundred goes to the unused code
    function automatic logic [REQ_W-1:0] pick_request(input int read_pct, input int load_pct,
                                                      input int epoch_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < read_pct)
            return REQ_READ;
        if (roll < read_pct + load_pct)
            return REQ_LOAD;
        if (roll < read_pct + load_pct + epoch_pct)
            return REQ_EPOCH;
        return REQ_UNUSED;
    endfunction

    // Offer one request and hold it until the transaction completes. Called and
    // returns at a falling edge; tvalid stays high into the next item of a burst.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [TIME_W-1:0] live,
                                input logic [TIME_W-1:0] epoch,
                                input logic [TIME_W-1:0] load);
        if (burst_left == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
        end
        s_axis_tdata  = IN_DATA_W'({load, epoch, live, req});
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_noisy(input logic [REQ_W-1:0] req);
        send_request(req, rand_time(), rand_time(), rand_time());
    endtask

    // Registers change only with the unit empty: drop tvalid, drain, then write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        cfg_writes++;
    endtask

    // Well-formed use: open an epoch, fill part of the log, then play it back
    // a little past its end so the underflow path can be reached too
    task automatic record_then_replay();
        int n_rec;
        n_rec = $urandom_range(4, 40);
        write_register(CFG_MODE, MODE_RECORD);
        write_register(CFG_LIVE_PRESENT, CFG_DATA_W'($urandom_range(0, 4) != 0));
        send_noisy(REQ_EPOCH);
        repeat (n_rec)
            send_noisy(pick_request(60, 37, 0));
        write_register(CFG_MODE, MODE_REPLAY);
        repeat (n_rec + $urandom_range(0, 6))
            send_noisy(pick_request(90, 5, 0));
    endtask

    // Noise: any mode, any request mix, epochs dropped in at random
    task automatic mixed_segment();
        write_register(CFG_MODE, MODE_W'($urandom_range(0, 3)));
        write_register(CFG_LIVE_PRESENT, CFG_DATA_W'($urandom_range(0, 1)));
        repeat ($urandom_range(20, 60))
            send_noisy(pick_request(55, 30, 8));
    endtask

    // Receiver: its own stall pattern, chosen anew at the end of each random span, plus a
    // long hold-off on request so the unit backs up into its input
    initial
    begin
        int style;
        int span;
        int hold_off_served;
        m_axis_tready   = 1'b0;
        hold_off_served = 0;
        forever
        begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(20, 80);
            repeat (span)
            begin
                @(negedge clk);
                if (hold_off_req != hold_off_served)
                begin
                    hold_off_served = hold_off_req;
                    m_axis_tready   = 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(negedge clk);
                end
                case (style)
                    0:       m_axis_tready = 1'b1;
                    1:       m_axis_tready = ($urandom_range(0, 3) != 0);
                    2:       m_axis_tready = ($urandom_range(0, 4) < 2);
                    default: m_axis_tready = ~m_axis_tready;
                endcase
            end
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        int random_start;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_MODE;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        burst_left    = 0;
        items_sent    = 0;
        cfg_writes    = 0;
        hold_off_req  = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: pass-through extremes and the unused request
        write_register(CFG_MODE, MODE_OFF);
        write_register(CFG_LIVE_PRESENT, CFG_DATA_W'(1));
        send_request(REQ_READ, '0, rand_time(), rand_time());
        send_request(REQ_READ, '1, rand_time(), rand_time());
        send_noisy(REQ_READ);
        send_noisy(REQ_UNUSED);
        // Preload three values under a fresh epoch
        send_request(REQ_EPOCH, rand_time(), '1, rand_time());
        send_request(REQ_LOAD, rand_time(), rand_time(), '1);
        send_request(REQ_LOAD, rand_time(), rand_time(), '0);
        send_noisy(REQ_LOAD);
        // Replay them, run past the end (live input ignored), then extend the
        // log in replay mode and pick the new entry up
        write_register(CFG_MODE, MODE_REPLAY);
        repeat (5) send_noisy(REQ_READ);
        send_noisy(REQ_LOAD);
        send_noisy(REQ_READ);
        // Record with and without a live source
        write_register(CFG_MODE, MODE_RECORD);
        send_noisy(REQ_READ);
        write_register(CFG_LIVE_PRESENT, CFG_DATA_W'(0));
        send_noisy(REQ_READ);
        // No live source in off mode returns the last value
        write_register(CFG_MODE, MODE_OFF);
        send_noisy(REQ_READ);
        // The unused mode passes live time through
        write_register(CFG_MODE, MODE_UNUSED);
        write_register(CFG_LIVE_PRESENT, CFG_DATA_W'(1));
        send_noisy(REQ_READ);
        send_request(REQ_EPOCH, rand_time(), '0, rand_time());

        // Random part; the receiver holds off at its start so the unit fills up
        hold_off_req++;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) != 0)
                record_then_replay();
            else
                mixed_segment();
        end

        // Fill the log completely: record-mode overflow and loads rejected when full
        write_register(CFG_MODE, MODE_RECORD);
        write_register(CFG_LIVE_PRESENT, CFG_DATA_W'(1));
        hold_off_req++;
        send_noisy(REQ_EPOCH);
        repeat (LOG_DEPTH + 12)
            send_noisy(pick_request(50, 50, 0));
        write_register(CFG_MODE, MODE_REPLAY);
        repeat (24)
            send_noisy(pick_request(85, 15, 0));

        // Drain and let the pipeline settle
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d requests with %0d register writes; %0d results checked.",
                 items_sent, cfg_writes, checked);
        $display("Covered all modes, absent live source, full log and replay past end.");
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

[time_read_record_replay_log_unit.f]
hdl/trrl_pkg.sv
hdl/trrl_log_ram.sv
hdl/time_read_record_replay_log_unit.sv
tb/tb_trrl_result_checker.sv
tb/tb_top.sv
